/* hdl/dsfm_pkg.sv */
// ----------------------------------------------------------------------------
// dsfm_pkg
// Shared constants, command codes and control structures of the direct sound
// FIFO mixer.
// ----------------------------------------------------------------------------
package dsfm_pkg;

    localparam int FIFO_DEPTH = 32;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam int OPQ_DEPTH  = 2;
    localparam int OPQ_PTR_W  = $clog2(OPQ_DEPTH);
    localparam int OPQ_CNT_W  = $clog2(OPQ_DEPTH + 1);

    localparam int MAX_PAIRS  = 64;
    localparam int PAIR_W     = $clog2(MAX_PAIRS);

    localparam int CPS_W      = 20;
    localparam int REM_W      = 21;
    localparam logic [CPS_W-1:0] MIN_CPS = 20'd128;

    // Input command codes
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_PUSH_A  = 3'd1;
    localparam logic [2:0] CMD_PUSH_B  = 3'd2;
    localparam logic [2:0] CMD_POP_A   = 3'd3;
    localparam logic [2:0] CMD_POP_B   = 3'd4;
    localparam logic [2:0] CMD_RESET_A = 3'd5;
    localparam logic [2:0] CMD_RESET_B = 3'd6;

    // Configuration register indexes
    localparam logic [2:0] CFG_MASTER_ENABLE     = 3'd0;
    localparam logic [2:0] CFG_FULL_VOLUME_A     = 3'd1;
    localparam logic [2:0] CFG_FULL_VOLUME_B     = 3'd2;
    localparam logic [2:0] CFG_ROUTE_A_RIGHT     = 3'd3;
    localparam logic [2:0] CFG_ROUTE_A_LEFT      = 3'd4;
    localparam logic [2:0] CFG_ROUTE_B_RIGHT     = 3'd5;
    localparam logic [2:0] CFG_ROUTE_B_LEFT      = 3'd6;
    localparam logic [2:0] CFG_CYCLES_PER_SAMPLE = 3'd7;

    localparam logic [CPS_W-1:0] CPS_RESET = 20'd16384;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_PUSH,
        OP_POP,
        OP_CLEAR
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic        chan_b;
        logic [31:0] word;
        logic [7:0]  elapsed;
    } op_t;

    typedef struct packed {
        logic             master_enable;
        logic             full_volume_a;
        logic             full_volume_b;
        logic             route_a_right;
        logic             route_a_left;
        logic             route_b_right;
        logic             route_b_left;
        logic [CPS_W-1:0] cycles_per_sample;
    } cfg_t;

    typedef struct packed {
        logic       push;
        logic [7:0] data;
        logic       pop;
        logic       clear;
    } chan_ctl_t;

    typedef struct packed {
        logic idle;
        logic emitting;
    } back_stat_t;

endpackage

/* hdl/dsfm_ram.sv */
// ----------------------------------------------------------------------------
// dsfm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dsfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/dsfm_chan.sv */
// ----------------------------------------------------------------------------
// dsfm_chan
// One sample channel: a circular byte FIFO in RAM, its fill count and the
// output latch that a pop loads from the FIFO head.
// ----------------------------------------------------------------------------
module dsfm_chan (
    input  logic                clk,
    input  logic                rst_n,
    input  dsfm_pkg::chan_ctl_t ctl,
    output logic [7:0]          latch
);

    logic [dsfm_pkg::PTR_W-1:0] head_reg, head_next;
    logic [dsfm_pkg::CNT_W-1:0] count_reg, count_next;
    logic [7:0]                 latch_reg, latch_next;
    logic                       pend_reg, pend_next;

    logic [dsfm_pkg::PTR_W:0]   tail_sum;
    logic [dsfm_pkg::PTR_W-1:0] tail;
    logic                       full;
    logic                       empty;
    logic                       wr_en;
    logic                       rd_en;
    logic [7:0]                 rd_data;

    assign full  = (count_reg == dsfm_pkg::CNT_W'(dsfm_pkg::FIFO_DEPTH));
    assign empty = (count_reg == '0);

    // Write position is head plus count, wrapped once around the depth.
    assign tail_sum = (dsfm_pkg::PTR_W+1)'(head_reg) + (dsfm_pkg::PTR_W+1)'(count_reg);
    assign tail = (tail_sum >= (dsfm_pkg::PTR_W+1)'(dsfm_pkg::FIFO_DEPTH))
                ? dsfm_pkg::PTR_W'(tail_sum - (dsfm_pkg::PTR_W+1)'(dsfm_pkg::FIFO_DEPTH))
                : dsfm_pkg::PTR_W'(tail_sum);

    assign wr_en = ctl.push && !full;
    assign rd_en = ctl.pop && !empty;

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        latch_next = latch_reg;
        pend_next  = 1'b0;
        if (pend_reg)
        begin
            latch_next = rd_data;
        end
        if (ctl.clear)
        begin
            head_next  = '0;
            count_next = '0;
            latch_next = '0;
        end
        else if (wr_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en)
        begin
            head_next  = (head_reg == dsfm_pkg::PTR_W'(dsfm_pkg::FIFO_DEPTH - 1))
                       ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
            pend_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            latch_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            latch_reg <= latch_next;
            pend_reg  <= pend_next;
        end
    end

    dsfm_ram #(
        .WIDTH (8),
        .DEPTH (dsfm_pkg::FIFO_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail),
        .wr_data (ctl.data),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    assign latch = latch_reg;

endmodule

/* hdl/dsfm_front.sv */
// ----------------------------------------------------------------------------
// dsfm_front
// Accepts input items, decodes the command and queues one operation for each
// item with a used command code, in a short register queue for the back end.
// ----------------------------------------------------------------------------
module dsfm_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [2:0]      cmd,
    input  logic [31:0]     fifo_word,
    input  logic [7:0]      elapsed,
    output logic            op_valid,
    output dsfm_pkg::op_t   op,
    input  logic            op_take
);

    dsfm_pkg::op_t                  q_reg [dsfm_pkg::OPQ_DEPTH];
    logic [dsfm_pkg::OPQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [dsfm_pkg::OPQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dsfm_pkg::OPQ_CNT_W-1:0] count_reg, count_next;

    dsfm_pkg::op_t dec_op;
    logic          dec_keep;
    logic          accept;
    logic          enq;
    logic          deq;

    assign in_stall = (count_reg == dsfm_pkg::OPQ_CNT_W'(dsfm_pkg::OPQ_DEPTH));
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        dec_op.kind    = dsfm_pkg::OP_TICK;
        dec_op.chan_b  = 1'b0;
        dec_op.word    = fifo_word;
        dec_op.elapsed = elapsed;
        dec_keep       = 1'b1;
        unique case (cmd) inside
            dsfm_pkg::CMD_TICK:
            begin
                dec_op.kind = dsfm_pkg::OP_TICK;
            end
            dsfm_pkg::CMD_PUSH_A, dsfm_pkg::CMD_PUSH_B:
            begin
                dec_op.kind   = dsfm_pkg::OP_PUSH;
                dec_op.chan_b = (cmd == dsfm_pkg::CMD_PUSH_B);
            end
            dsfm_pkg::CMD_POP_A, dsfm_pkg::CMD_POP_B:
            begin
                dec_op.kind   = dsfm_pkg::OP_POP;
                dec_op.chan_b = (cmd == dsfm_pkg::CMD_POP_B);
            end
            dsfm_pkg::CMD_RESET_A, dsfm_pkg::CMD_RESET_B:
            begin
                dec_op.kind   = dsfm_pkg::OP_CLEAR;
                dec_op.chan_b = (cmd == dsfm_pkg::CMD_RESET_B);
            end
            default:
            begin
                // The unused code is taken and then forgotten.
                dec_keep = 1'b0;
            end
        endcase
    end

    assign enq      = accept && dec_keep;
    assign op_valid = (count_reg != '0);
    assign deq      = op_take && op_valid;
    assign op       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (enq)
        begin
            wr_ptr_next = (wr_ptr_reg == dsfm_pkg::OPQ_PTR_W'(dsfm_pkg::OPQ_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (deq)
        begin
            rd_ptr_next = (rd_ptr_reg == dsfm_pkg::OPQ_PTR_W'(dsfm_pkg::OPQ_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (enq && !deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (deq && !enq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wr_ptr_reg] <= dec_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hdl/dsfm_back.sv */
// ----------------------------------------------------------------------------
// dsfm_back
// Carries out queued operations: byte pushes, pops and clears on the two
// channels, and the tick loop that emits mixed stereo pairs.
// ----------------------------------------------------------------------------
module dsfm_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dsfm_pkg::cfg_t          cfg,
    input  logic                    op_valid,
    input  dsfm_pkg::op_t           op,
    output logic                    op_take,
    output dsfm_pkg::chan_ctl_t     ctl_a,
    output dsfm_pkg::chan_ctl_t     ctl_b,
    input  logic [7:0]              latch_a,
    input  logic [7:0]              latch_b,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [14:0]             left_sample,
    output logic [14:0]             right_sample,
    output logic                    last,
    output dsfm_pkg::back_stat_t    stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_POP_WAIT,
        ST_EMIT
    } state_t;

    state_t                              state_reg, state_next;
    logic [31:0]                         word_reg, word_next;
    logic                                chan_b_reg, chan_b_next;
    logic [1:0]                          idx_reg, idx_next;
    logic signed [dsfm_pkg::REM_W-1:0]   rem_reg, rem_next;
    logic signed [dsfm_pkg::REM_W-1:0]   sum_reg, sum_next;
    logic [8:0]                          mix_l_reg, mix_l_next;
    logic [8:0]                          mix_r_reg, mix_r_next;
    logic [dsfm_pkg::PAIR_W-1:0]         n_reg, n_next;
    logic                                out_valid_reg, out_valid_next;
    logic [14:0]                         left_reg, left_next;
    logic [14:0]                         right_reg, right_next;
    logic                                last_reg, last_next;

    logic [dsfm_pkg::CPS_W-1:0]          cps;
    logic [7:0]                          da;
    logic [7:0]                          db;
    logic [8:0]                          l_calc;
    logic [8:0]                          r_calc;
    logic signed [dsfm_pkg::REM_W-1:0]   sum_calc;
    logic signed [dsfm_pkg::REM_W-1:0]   sub_calc;
    logic                                last_calc;
    logic                                out_free;
    dsfm_pkg::chan_ctl_t                 ctl;

    assign cps = (cfg.cycles_per_sample < dsfm_pkg::MIN_CPS)
               ? dsfm_pkg::MIN_CPS : cfg.cycles_per_sample;

    assign da = cfg.full_volume_a ? latch_a : {1'b0, latch_a[7:1]};
    assign db = cfg.full_volume_b ? latch_b : {1'b0, latch_b[7:1]};

    assign l_calc = ((cfg.master_enable && cfg.route_a_left)  ? {1'b0, da} : 9'd0)
                  + ((cfg.master_enable && cfg.route_b_left)  ? {1'b0, db} : 9'd0);
    assign r_calc = ((cfg.master_enable && cfg.route_a_right) ? {1'b0, da} : 9'd0)
                  + ((cfg.master_enable && cfg.route_b_right) ? {1'b0, db} : 9'd0);

    assign sum_calc = rem_reg + $signed({8'd0, op.elapsed, 5'd0});
    // The sum is positive whenever a pair is emitted, so the difference stays in range.
    assign sub_calc = sum_reg - $signed({1'b0, cps});
    assign last_calc = (sub_calc <= 0) ||
                       (n_reg == dsfm_pkg::PAIR_W'(dsfm_pkg::MAX_PAIRS - 1));
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        word_next      = word_reg;
        chan_b_next    = chan_b_reg;
        idx_next       = idx_reg;
        rem_next       = rem_reg;
        sum_next       = sum_reg;
        mix_l_next     = mix_l_reg;
        mix_r_next     = mix_r_reg;
        n_next         = n_reg;
        out_valid_next = out_valid_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        last_next      = last_reg;
        op_take        = 1'b0;
        ctl            = '0;
        ctl.data       = word_reg[{idx_reg, 3'b000} +: 8];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                chan_b_next = op.chan_b;
                if (op_valid)
                begin
                    op_take = 1'b1;
                    unique case (op.kind)
                        dsfm_pkg::OP_PUSH:
                        begin
                            word_next  = op.word;
                            idx_next   = '0;
                            state_next = ST_PUSH;
                        end
                        dsfm_pkg::OP_POP:
                        begin
                            ctl.pop    = 1'b1;
                            state_next = ST_POP_WAIT;
                        end
                        dsfm_pkg::OP_CLEAR:
                        begin
                            ctl.clear = 1'b1;
                        end
                        dsfm_pkg::OP_TICK:
                        begin
                            if (sum_calc > 0)
                            begin
                                sum_next   = sum_calc;
                                mix_l_next = l_calc;
                                mix_r_next = r_calc;
                                n_next     = '0;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                rem_next = sum_calc;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PUSH:
            begin
                ctl.push = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == 2'd3)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP_WAIT:
            begin
                // The latch loads from the RAM read in this cycle.
                state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    left_next      = {mix_l_reg, 6'd0};
                    right_next     = {mix_r_reg, 6'd0};
                    last_next      = last_calc;
                    sum_next       = sub_calc;
                    n_next         = n_reg + 1'b1;
                    if (last_calc)
                    begin
                        rem_next   = sub_calc;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ctl_a = chan_b_next ? '0 : ctl;
    assign ctl_b = chan_b_next ? ctl : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chan_b_reg    <= 1'b0;
            idx_reg       <= '0;
            rem_reg       <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chan_b_reg    <= chan_b_next;
            idx_reg       <= idx_next;
            rem_reg       <= rem_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        sum_reg   <= sum_next;
        mix_l_reg <= mix_l_next;
        mix_r_reg <= mix_r_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        last_reg  <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign left_sample   = left_reg;
    assign right_sample  = right_reg;
    assign last          = last_reg;
    assign stat.idle     = (state_reg == ST_IDLE);
    assign stat.emitting = (state_reg == ST_EMIT);

endmodule

/* hdl/direct_sound_fifo_mixer.sv */
// ----------------------------------------------------------------------------
// direct_sound_fifo_mixer
// Two 8-bit sample FIFOs with latches, and a tick-driven stereo mixer that
// emits pairs of scaled samples.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Payload
//  in       sink       in_valid / in_stall     cmd, fifo_word, elapsed
//  out      source     out_valid / out_stall   left_sample, right_sample, last
//  cfg      sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  An accepted item is registered in the operation queue before the back
//  end sees it. In the back end a push is taken and then writes its bytes to
//  the RAM one at a time, a pop is taken and then loads the latch, a clear or
//  a tick that emits nothing is done when it is taken, and a tick that emits
//  pairs sends them one after another while the output is not stalled. A
//  two-entry operation queue lets the front keep taking items while the back
//  end works. Reset empties both FIFOs, clears the latches and the remainder,
//  and returns the configuration to its reset values; FIFO contents are not
//  cleared. cfg_ready is always high.
// ----------------------------------------------------------------------------
module direct_sound_fifo_mixer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [31:0] fifo_word,
    input  logic [7:0]  elapsed,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [14:0] left_sample,
    output logic [14:0] right_sample,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    dsfm_pkg::cfg_t       cfg_reg, cfg_next;
    dsfm_pkg::op_t        op;
    logic                 op_valid;
    logic                 op_take;
    dsfm_pkg::chan_ctl_t  ctl_a;
    dsfm_pkg::chan_ctl_t  ctl_b;
    logic [7:0]           latch_a;
    logic [7:0]           latch_b;
    dsfm_pkg::back_stat_t bk_stat;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dsfm_pkg::CFG_MASTER_ENABLE:     cfg_next.master_enable = cfg_data[0];
                dsfm_pkg::CFG_FULL_VOLUME_A:     cfg_next.full_volume_a = cfg_data[0];
                dsfm_pkg::CFG_FULL_VOLUME_B:     cfg_next.full_volume_b = cfg_data[0];
                dsfm_pkg::CFG_ROUTE_A_RIGHT:     cfg_next.route_a_right = cfg_data[0];
                dsfm_pkg::CFG_ROUTE_A_LEFT:      cfg_next.route_a_left  = cfg_data[0];
                dsfm_pkg::CFG_ROUTE_B_RIGHT:     cfg_next.route_b_right = cfg_data[0];
                dsfm_pkg::CFG_ROUTE_B_LEFT:      cfg_next.route_b_left  = cfg_data[0];
                dsfm_pkg::CFG_CYCLES_PER_SAMPLE: cfg_next.cycles_per_sample = cfg_data;
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= dsfm_pkg::cfg_t'({7'd0, dsfm_pkg::CPS_RESET});
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dsfm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .fifo_word (fifo_word),
        .elapsed   (elapsed),
        .op_valid  (op_valid),
        .op        (op),
        .op_take   (op_take)
    );

    dsfm_chan u_chan_a (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl_a),
        .latch (latch_a)
    );

    dsfm_chan u_chan_b (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl_b),
        .latch (latch_b)
    );

    dsfm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .op_valid     (op_valid),
        .op           (op),
        .op_take      (op_take),
        .ctl_a        (ctl_a),
        .ctl_b        (ctl_b),
        .latch_a      (latch_a),
        .latch_b      (latch_b),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .last         (last),
        .stat         (bk_stat)
    );

    // The back end takes operations only when one is queued and it is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        op_take |-> (op_valid && bk_stat.idle))
        else $error("operation taken while none queued or back end busy");

    // A full operation queue always offers an operation.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> op_valid)
        else $error("input stalled with an empty operation queue");

    // After a pair that is not the last one, the tick loop is still running.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |-> bk_stat.emitting)
        else $error("non-final pair delivered with no tick in progress");

endmodule
